// File: hdl/fcr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcr_pkg
// Shared constants, twiddle tables and fixed-point helpers for the FFT
// response correction block.
// ----------------------------------------------------------------------------
package fcr_pkg;

  localparam int unsigned FRAME_LEN  = 1024;
  localparam int unsigned LOG2N      = $clog2(FRAME_LEN);
  localparam int unsigned HALF_LEN   = FRAME_LEN / 2;
  localparam int unsigned QTR_LEN    = FRAME_LEN / 4;
  localparam int unsigned OCT_LEN    = FRAME_LEN / 8;
  localparam int unsigned RESP_FRAC  = 16;
  localparam int unsigned TW_FRAC    = 30;
  localparam int unsigned DW         = 48;
  localparam int unsigned SMP_W      = 24;
  localparam int unsigned RESP_W     = 32;
  localparam int unsigned TW_W       = 32;
  localparam int unsigned ADDR_W     = LOG2N;
  localparam int unsigned BIN_W      = 10;
  localparam int unsigned TAB_DEPTH  = HALF_LEN + 1;
  localparam int unsigned TAB_AW     = $clog2(TAB_DEPTH);
  localparam int unsigned STG_W      = $clog2(LOG2N);
  localparam int unsigned TW_ENTRIES = OCT_LEN + 1;
  localparam int unsigned TW_IDX_W   = $clog2(TW_ENTRIES);
  localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
  localparam logic [63:0] PI_Q30     = 64'd3373259426;

  // factorial step divisors of the series: cosine row, then sine row
  localparam logic [63:0] TAYLOR_DIV [2][9] = '{
    '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306},
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342}
  };

  localparam int unsigned CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_BIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BIN = 2'd1;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic signed [DW-1:0] DATA_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DATA_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef logic signed [DW-1:0] data_t;
  typedef logic signed [TW_W-1:0] tw_tab_t [TW_ENTRIES];

  typedef struct packed {
    logic signed [TW_W-1:0] c;
    logic signed [TW_W-1:0] s;
  } tw_t;

  // Q30 Taylor series on the first octant: cosine, or sine when odd is set
  function automatic logic signed [63:0] taylor(logic [63:0] x, logic odd);
    logic [63:0] term;
    logic [63:0] x2;
    logic signed [63:0] sum;
    term = odd ? x : ONE_Q30;
    x2   = (x * x) >> 30;
    sum  = signed'(term);
    for (int i = 1; i <= 9; i++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[odd][i-1];
      if (i[0]) sum = sum - signed'(term);
      else      sum = sum + signed'(term);
    end
    return sum;
  endfunction

  function automatic tw_tab_t build_tw(logic odd);
    tw_tab_t tab;
    logic [63:0] th;
    for (int r = 0; r < TW_ENTRIES; r++) begin
      th     = (64'(r) * 64'd2 * PI_Q30 + 64'(HALF_LEN)) >> LOG2N;
      tab[r] = TW_W'(taylor(th, odd));
    end
    return tab;
  endfunction

  localparam tw_tab_t TW_COS = build_tw(1'b0);
  localparam tw_tab_t TW_SIN = build_tw(1'b1);

  // cos and sin of 2*pi*k/N for k in 0..N/2-1
  function automatic tw_t tw_lookup(logic [LOG2N-2:0] k);
    tw_t w;
    logic neg;
    logic swap;
    logic [LOG2N-2:0] m;
    logic [TW_IDX_W-1:0] r;
    neg  = k > (LOG2N-1)'(QTR_LEN);
    m    = neg ? ~k + 1'b1 : k;
    swap = m > (LOG2N-1)'(OCT_LEN);
    r    = TW_IDX_W'(swap ? (LOG2N-1)'(QTR_LEN) - m : m);
    w.c  = swap ? TW_SIN[r] : TW_COS[r];
    w.s  = swap ? TW_COS[r] : TW_SIN[r];
    if (neg) w.c = -w.c;
    return w;
  endfunction

  function automatic logic [ADDR_W-1:0] bit_rev(logic [ADDR_W-1:0] x);
    logic [ADDR_W-1:0] r;
    for (int b = 0; b < ADDR_W; b++) r[ADDR_W-1-b] = x[b];
    return r;
  endfunction

  function automatic data_t sat_data(logic signed [DW:0] v);
    data_t r;
    if (v[DW] != v[DW-1]) r = v[DW] ? DATA_MIN : DATA_MAX;
    else                  r = v[DW-1:0];
    return r;
  endfunction

  function automatic data_t add_sat(data_t a, data_t b);
    return sat_data({a[DW-1], a} + {b[DW-1], b});
  endfunction

  function automatic data_t sub_sat(data_t a, data_t b);
    return sat_data({a[DW-1], a} - {b[DW-1], b});
  endfunction

endpackage
`default_nettype wire

// File: hdl/fft_response_correction.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fft_response_correction
// Frequency-domain instrument response correction of a seismic trace.
// ----------------------------------------------------------------------------
// Load entries (func 0) can be accepted back to back; after each sample
// (func 1) the input port drops ready before it takes the next item. The
// last sample of a frame starts the frame processing, during which neither
// the input nor the config port is ready: a copy into bit-reversed order,
// 5120 butterflies for the forward FFT, a 513-bin response pass and 5120
// butterflies for the inverse FFT. The butterflies and the response pass
// share the single pipelined 48x32 multiplier (two 24x32 partial products,
// four products per butterfly) and the single write port of each spectrum
// RAM. Each sample returns the sample at its position of the previous
// processed frame; the first frame returns zeros.
// ----------------------------------------------------------------------------
module fft_response_correction (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 func_i,
  input  logic [fcr_pkg::BIN_W-1:0]            bin_index_i,
  input  logic signed [fcr_pkg::RESP_W-1:0]    resp_re_i,
  input  logic signed [fcr_pkg::RESP_W-1:0]    resp_im_i,
  input  logic signed [fcr_pkg::SMP_W-1:0]     sample_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [fcr_pkg::DW-1:0]        sample_out_o,
  output logic                                 frame_last_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fcr_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [fcr_pkg::BIN_W-1:0]            cfg_data_i
);
  import fcr_pkg::*;

  typedef enum logic [17:0] {
    ST_IDLE = 18'h00001,
    ST_CP   = 18'h00002,
    ST_RA   = 18'h00004,
    ST_RB   = 18'h00008,
    ST_MR   = 18'h00010,
    ST_LD   = 18'h00020,
    ST_M0   = 18'h00040,
    ST_M1   = 18'h00080,
    ST_M2   = 18'h00100,
    ST_M3   = 18'h00200,
    ST_C0   = 18'h00400,
    ST_C1   = 18'h00800,
    ST_C2   = 18'h01000,
    ST_TW   = 18'h02000,
    ST_WA   = 18'h04000,
    ST_WB   = 18'h08000,
    ST_MW0  = 18'h10000,
    ST_MW1  = 18'h20000
  } state_e;

  state_e state_q, state_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [BIN_W-1:0]  low_q, low_d, high_q, high_d;
  logic              first_done_q, first_done_d;
  logic              primed_q, primed_d;
  logic              out_valid_q, out_valid_d;
  logic [ADDR_W:0]   cnt_q, cnt_d;
  logic [STG_W-1:0]  stage_q, stage_d;
  logic [LOG2N-2:0]  bc_q, bc_d;
  logic              inv_q, inv_d;
  logic              mulp_q, mulp_d;

  logic in_acc, smp_acc, cfg_acc;

  // datapath
  data_t sample_out_q;
  logic  frame_last_q;
  logic  kept_q;
  data_t ua_q, ui_q, br_q, bi_q;
  logic signed [TW_W-1:0] wr_q, wi_q;
  data_t pr0_q, pr1_q, pr2_q, pr3_q, tr_q, ti_q;

  // multiplier pipeline
  data_t                  mul_a;
  logic signed [TW_W-1:0] mul_b;
  logic [DW-1:0]          a_abs;
  logic [TW_W-1:0]        b_abs;
  logic [55:0]            m1_p_d, m1_p_q, hi_prod;
  logic [23:0]            m1_ahi_q;
  logic [TW_W-1:0]        m1_ub_q;
  logic                   m1_neg_q, m1_sh_q;
  logic [79:0]            m2_p_d, m2_p_q, rnd, q3;
  logic                   m2_neg_q, m2_sh_q;
  data_t                  res_d, res_q;

  // addressing
  logic [LOG2N-2:0]  bf_mask, bf_j, tw_idx;
  logic [ADDR_W-1:0] bf_a, bf_b, k, k_neg, cnt_m1, rd_addr;
  logic              k_zero, k_half, last_stage, kept_d;
  logic [BIN_W-1:0]  hi_clamp;
  tw_t               tw;

  // memories
  logic [SMP_W-1:0]    inp_rdata;
  logic [2*RESP_W-1:0] tab_rdata;
  logic [2*DW-1:0]     a_rdata, b_rdata, buf_rdata, bf_wdata, a_wdata, b_wdata;
  logic                a_we, b_we;
  logic [ADDR_W-1:0]   a_waddr, b_waddr, b_raddr;

  assign in_ready_o  = (state_q == ST_IDLE) && primed_q && (!out_valid_q || out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign smp_acc     = in_acc && (func_i == FUNC_SAMPLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign frame_last_o = frame_last_q;

  assign bf_mask    = ~({(LOG2N-1){1'b1}} << stage_q);
  assign bf_j       = bc_q & bf_mask;
  assign bf_a       = {bc_q & ~bf_mask, 1'b0} | {1'b0, bf_j};
  assign bf_b       = bf_a | (ADDR_W'(1) << stage_q);
  assign tw_idx     = bf_j << (STG_W'(LOG2N - 1) - stage_q);
  assign tw         = tw_lookup(tw_idx);
  assign last_stage = stage_q == STG_W'(LOG2N - 1);

  assign k      = cnt_q[ADDR_W-1:0];
  assign k_neg  = ~k + 1'b1;
  assign k_zero = k == '0;
  assign k_half = k == ADDR_W'(HALF_LEN);
  assign cnt_m1 = k - 1'b1;

  assign hi_clamp = (high_q > BIN_W'(HALF_LEN)) ? BIN_W'(HALF_LEN) : high_q;
  assign kept_d   = (low_q < BIN_W'(HALF_LEN)) && (hi_clamp >= low_q) &&
                    (BIN_W'(k) >= low_q) && (BIN_W'(k) <= hi_clamp);

  // control
  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    low_d        = low_q;
    high_d       = high_q;
    first_done_d = first_done_q;
    cnt_d        = cnt_q;
    stage_d      = stage_q;
    bc_d         = bc_q;
    inv_d        = inv_q;
    mulp_d       = mulp_q;
    primed_d     = (state_q == ST_IDLE) && !smp_acc;
    out_valid_d  = smp_acc ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

    if (cfg_acc) begin
      case (cfg_index_i)
        CFG_LOW_BIN:  low_d  = cfg_data_i;
        CFG_HIGH_BIN: high_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (smp_acc) begin
          pos_d = pos_q + 1'b1;
          if (&pos_q) begin
            state_d = ST_CP;
            cnt_d   = '0;
          end
        end
      end
      ST_CP: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[ADDR_W]) begin
          state_d = ST_RA;
          stage_d = '0;
          bc_d    = '0;
          inv_d   = 1'b0;
          mulp_d  = 1'b0;
        end
      end
      ST_RA: state_d = ST_RB;
      ST_RB: state_d = ST_LD;
      ST_MR: state_d = ST_LD;
      ST_LD: state_d = ST_M0;
      ST_M0: state_d = ST_M1;
      ST_M1: state_d = ST_M2;
      ST_M2: state_d = ST_M3;
      ST_M3: state_d = ST_C0;
      ST_C0: state_d = ST_C1;
      ST_C1: state_d = ST_C2;
      ST_C2: state_d = ST_TW;
      ST_TW: state_d = mulp_q ? ST_MW0 : ST_WA;
      ST_WA: state_d = ST_WB;
      ST_WB: begin
        bc_d    = bc_q + 1'b1;
        state_d = ST_RA;
        if (&bc_q) begin
          stage_d = stage_q + 1'b1;
          if (last_stage) begin
            if (inv_q) begin
              state_d      = ST_IDLE;
              first_done_d = 1'b1;
            end else begin
              state_d = ST_MR;
              mulp_d  = 1'b1;
              cnt_d   = '0;
            end
          end
        end
      end
      ST_MW0: begin
        if (k_half) begin
          state_d = ST_RA;
          mulp_d  = 1'b0;
          inv_d   = 1'b1;
          stage_d = '0;
          bc_d    = '0;
        end else if (k_zero) begin
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_MR;
        end else begin
          state_d = ST_MW1;
        end
      end
      ST_MW1: begin
        cnt_d   = cnt_q + 1'b1;
        state_d = ST_MR;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pos_q        <= '0;
      low_q        <= '0;
      high_q       <= BIN_W'(HALF_LEN);
      first_done_q <= 1'b0;
      primed_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
      stage_q      <= '0;
      bc_q         <= '0;
      inv_q        <= 1'b0;
      mulp_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      pos_q        <= pos_d;
      low_q        <= low_d;
      high_q       <= high_d;
      first_done_q <= first_done_d;
      primed_q     <= primed_d;
      out_valid_q  <= out_valid_d;
      cnt_q        <= cnt_d;
      stage_q      <= stage_d;
      bc_q         <= bc_d;
      inv_q        <= inv_d;
      mulp_q       <= mulp_d;
    end
  end

  // shared multiplier: |a|*|b|, rounded half away from zero, saturated
  always_comb begin
    mul_a = br_q;
    mul_b = wr_q;
    unique case (state_q)
      ST_M1:   begin mul_a = bi_q; mul_b = wi_q; end
      ST_M2:   begin mul_a = br_q; mul_b = wi_q; end
      ST_M3:   begin mul_a = bi_q; mul_b = wr_q; end
      default: ;
    endcase
  end

  assign a_abs   = mul_a[DW-1] ? DW'(-mul_a) : DW'(mul_a);
  assign b_abs   = mul_b[TW_W-1] ? TW_W'(-mul_b) : TW_W'(mul_b);
  assign m1_p_d  = a_abs[23:0] * b_abs;
  assign hi_prod = m1_ahi_q * m1_ub_q;
  assign rnd     = m1_sh_q ? (80'd1 << (RESP_FRAC - 1)) : (80'd1 << (TW_FRAC - 1));
  assign m2_p_d  = {24'd0, m1_p_q} + {hi_prod, 24'd0} + rnd;
  assign q3      = m2_sh_q ? (m2_p_q >> RESP_FRAC) : (m2_p_q >> TW_FRAC);

  always_comb begin
    if (|q3[79:DW-1]) res_d = m2_neg_q ? DATA_MIN : DATA_MAX;
    else              res_d = m2_neg_q ? -signed'(q3[DW-1:0]) : signed'(q3[DW-1:0]);
  end

  always_ff @(posedge clk_i) begin
    m1_p_q   <= m1_p_d;
    m1_ahi_q <= a_abs[DW-1:24];
    m1_ub_q  <= b_abs;
    m1_neg_q <= mul_a[DW-1] ^ mul_b[TW_W-1];
    m1_sh_q  <= mulp_q;
    m2_p_q   <= m2_p_d;
    m2_neg_q <= m1_neg_q;
    m2_sh_q  <= m1_sh_q;
    res_q    <= res_d;
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      sample_out_q <= first_done_q ? data_t'(b_rdata[2*DW-1:DW]) : '0;
      frame_last_q <= &pos_q;
    end
    if (state_q == ST_RA) begin
      wr_q <= tw.c;
      wi_q <= inv_q ? tw.s : -tw.s;
    end
    if (state_q == ST_RB) begin
      ua_q <= buf_rdata[2*DW-1:DW];
      ui_q <= buf_rdata[DW-1:0];
    end
    if (state_q == ST_MR) kept_q <= kept_d;
    if (state_q == ST_LD) begin
      br_q <= buf_rdata[2*DW-1:DW];
      bi_q <= buf_rdata[DW-1:0];
      if (mulp_q) begin
        wr_q <= tab_rdata[2*RESP_W-1:RESP_W];
        wi_q <= tab_rdata[RESP_W-1:0];
      end
    end
    if (state_q == ST_M3) pr0_q <= res_q;
    if (state_q == ST_C0) pr1_q <= res_q;
    if (state_q == ST_C1) pr2_q <= res_q;
    if (state_q == ST_C2) pr3_q <= res_q;
    if (state_q == ST_TW) begin
      tr_q <= sub_sat(pr0_q, pr1_q);
      ti_q <= add_sat(pr2_q, pr3_q);
    end
  end

  // memory ports
  assign rd_addr   = (state_q == ST_RA) ? bf_a : ((state_q == ST_RB) ? bf_b : k);
  assign b_raddr   = (state_q == ST_IDLE) ? pos_q : rd_addr;
  assign buf_rdata = inv_q ? b_rdata : a_rdata;

  assign bf_wdata = (state_q == ST_WA) ?
                    {add_sat(ua_q, tr_q), add_sat(ui_q, ti_q)} :
                    {sub_sat(ua_q, tr_q), sub_sat(ui_q, ti_q)};

  assign a_we    = ((state_q == ST_CP) && (cnt_q != '0)) ||
                   (!inv_q && ((state_q == ST_WA) || (state_q == ST_WB)));
  assign a_waddr = (state_q == ST_CP) ? bit_rev(cnt_m1) :
                   ((state_q == ST_WA) ? bf_a : bf_b);
  assign a_wdata = (state_q == ST_CP) ?
                   {{(DW-SMP_W){inp_rdata[SMP_W-1]}}, inp_rdata, {DW{1'b0}}} : bf_wdata;

  assign b_we = (state_q == ST_MW0) || (state_q == ST_MW1) ||
                (inv_q && ((state_q == ST_WA) || (state_q == ST_WB)));

  always_comb begin
    b_waddr = (state_q == ST_WA) ? bf_a : bf_b;
    b_wdata = bf_wdata;
    unique case (state_q)
      ST_MW0: begin
        b_waddr = bit_rev(k);
        b_wdata = kept_q ? {tr_q, (k_zero || k_half) ? data_t'('0) : ti_q} : '0;
      end
      ST_MW1: begin
        b_waddr = bit_rev(k_neg);
        b_wdata = kept_q ? {tr_q, sub_sat('0, ti_q)} : '0;
      end
      default: ;
    endcase
  end

  fcr_ram #(.WIDTH(SMP_W), .DEPTH(FRAME_LEN)) u_inp_ram (
    .clk_i   (clk_i),
    .we_i    (smp_acc),
    .waddr_i (pos_q),
    .wdata_i (sample_in_i),
    .raddr_i (k),
    .rdata_o (inp_rdata)
  );

  fcr_ram #(.WIDTH(2*RESP_W), .DEPTH(TAB_DEPTH)) u_tab_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && (func_i == FUNC_LOAD) && (bin_index_i <= BIN_W'(HALF_LEN))),
    .waddr_i (TAB_AW'(bin_index_i)),
    .wdata_i ({resp_re_i, resp_im_i}),
    .raddr_i (TAB_AW'(k)),
    .rdata_o (tab_rdata)
  );

  fcr_ram #(.WIDTH(2*DW), .DEPTH(FRAME_LEN)) u_spec_a_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .raddr_i (rd_addr),
    .rdata_o (a_rdata)
  );

  fcr_ram #(.WIDTH(2*DW), .DEPTH(FRAME_LEN)) u_spec_b_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

endmodule
`default_nettype wire

// File: hdl/fcr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcr_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module fcr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
